>>> src/id3tfe_pkg.sv
// Shared types, constants and helpers for the ID3v2 text frame extractor.
// Used by every module in src; depends on nothing else.
package id3tfe_pkg;

  localparam int TEXT_BUFFER_MAX = 256;
  localparam int MAX_TEXT_FRAME = 512;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);

  localparam logic [0:0] REG_TITLE_SIZE = 1'b0;
  localparam logic [0:0] REG_ARTIST_SIZE = 1'b1;
  localparam logic [8:0] BUF_SIZE_RESET = 9'd256;

  localparam logic [7:0] MAGIC_0 = 8'h49;
  localparam logic [7:0] MAGIC_1 = 8'h44;
  localparam logic [7:0] MAGIC_2 = 8'h33;
  localparam logic [7:0] MIN_VERSION = 8'h03;
  localparam logic [7:0] SYNCSAFE_VERSION = 8'h04;
  localparam logic [31:0] ID_TIT2 = 32'h5449_5432;
  localparam logic [31:0] ID_TPE1 = 32'h5450_4531;
  localparam logic [7:0] FLAG_MASK = 8'h0C;
  localparam logic [7:0] ENC_UTF16_BOM = 8'h01;
  localparam logic [7:0] ENC_UTF16_BE = 8'h02;
  localparam logic [7:0] BOM_BE = 8'hFE;
  localparam logic [7:0] BOM_LE = 8'hFF;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DEL = 8'h7F;
  localparam logic [7:0] PAD_BYTE = 8'h00;

  typedef enum logic [2:0] {
    PH_TAG_HDR,
    PH_FRAME_HDR,
    PH_PAYLOAD,
    PH_SKIP,
    PH_IDLE
  } phase_t;

  typedef struct packed {
    logic       which;
    logic       start;
    logic       cand;
    logic [7:0] code;
    logic       last;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [8:0] eff_size(input logic [8:0] r);
    logic [12:0] v;
    v = 13'(r);
    if (v > 13'(TEXT_BUFFER_MAX)) v = 13'(TEXT_BUFFER_MAX);
    if (v > 13'd256) v = 13'd256;
    return v[8:0];
  endfunction

endpackage

>>> src/id3tfe_front.sv
// Front end: tag and frame header parser that classifies payload bytes.
// Depends on id3tfe_pkg; pushes one record per relevant byte into the queue.
module id3tfe_front #(
  parameter int MAX_TEXT_FRAME = id3tfe_pkg::MAX_TEXT_FRAME
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                start_of_file,
  input  logic [8:0]          title_size,
  input  logic [8:0]          artist_size,
  output logic                push,
  output id3tfe_pkg::rec_t    rec
);

  localparam int IW = (MAX_TEXT_FRAME > 2) ? $clog2(MAX_TEXT_FRAME) : 1;

  id3tfe_pkg::phase_t phase, phase_next;
  logic [3:0]  hcount, hcount_next;
  logic        is_v4, is_v4_next;
  logic [27:0] tag_size, tag_size_next;
  logic [32:0] tag_pos, tag_pos_next;
  logic [31:0] frame_id, frame_id_next;
  logic [31:0] size_raw, size_raw_next;
  logic [31:0] remaining, remaining_next;
  logic        which, which_next;
  logic [7:0]  encoding, encoding_next;
  logic [IW-1:0] pidx, pidx_next;
  logic        take2, take2_next;
  logic [7:0]  pending, pending_next;

  id3tfe_pkg::phase_t ph_cur;
  logic [3:0]  n;
  logic [27:0] tsize_cur;
  logic [27:0] tsize_new;
  logic        bad_hdr;
  logic [31:0] fsz;
  logic [32:0] pos_plus;
  logic        frame_ok;
  logic        more;
  logic        utf16;
  logic [7:0]  cchar;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= id3tfe_pkg::PH_TAG_HDR;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hcount   <= '0;
      is_v4    <= 1'b0;
      tag_size <= '0;
      tag_pos  <= '0;
      remaining <= '0;
      which    <= 1'b0;
      encoding <= '0;
      pidx     <= '0;
      take2    <= 1'b0;
      pending  <= '0;
    end else begin
      hcount   <= hcount_next;
      is_v4    <= is_v4_next;
      tag_size <= tag_size_next;
      tag_pos  <= tag_pos_next;
      remaining <= remaining_next;
      which    <= which_next;
      encoding <= encoding_next;
      pidx     <= pidx_next;
      take2    <= take2_next;
      pending  <= pending_next;
    end
    frame_id <= frame_id_next;
    size_raw <= size_raw_next;
  end

  always_comb begin
    ph_cur    = start_of_file ? id3tfe_pkg::PH_TAG_HDR : phase;
    n         = start_of_file ? 4'd0 : hcount;
    tsize_cur = start_of_file ? 28'd0 : tag_size;
    tsize_new = {tsize_cur[20:0], data_byte[6:0]};
    bad_hdr   = (n == 4'd0 && data_byte != id3tfe_pkg::MAGIC_0) ||
                (n == 4'd1 && data_byte != id3tfe_pkg::MAGIC_1) ||
                (n == 4'd2 && data_byte != id3tfe_pkg::MAGIC_2) ||
                (n == 4'd3 && data_byte < id3tfe_pkg::MIN_VERSION);
    fsz       = is_v4 ? {4'd0, size_raw[30:24], size_raw[22:16], size_raw[14:8],
                         size_raw[6:0]} : size_raw;
    pos_plus  = tag_pos + 33'd10 + 33'(fsz);
    frame_ok  = ((data_byte & id3tfe_pkg::FLAG_MASK) == 8'd0) && (fsz != 32'd0) &&
                (fsz < 32'(MAX_TEXT_FRAME));
    more      = (tag_pos + 33'd10) < 33'(tag_size);
    utf16     = (encoding == id3tfe_pkg::ENC_UTF16_BOM) ||
                (encoding == id3tfe_pkg::ENC_UTF16_BE);
    cchar     = take2 ? data_byte : pending;

    phase_next     = phase;
    hcount_next    = hcount;
    is_v4_next     = is_v4;
    tag_size_next  = tag_size;
    tag_pos_next   = tag_pos;
    frame_id_next  = frame_id;
    size_raw_next  = size_raw;
    remaining_next = remaining;
    which_next     = which;
    encoding_next  = encoding;
    pidx_next      = pidx;
    take2_next     = take2;
    pending_next   = pending;
    push           = 1'b0;
    rec            = '0;
    rec.which      = which;
    rec.code       = data_byte;

    if (accept) begin
      phase_next    = ph_cur;
      hcount_next   = n;
      tag_size_next = tsize_cur;
      case (ph_cur)
        id3tfe_pkg::PH_TAG_HDR: begin
          if (bad_hdr) begin
            phase_next = id3tfe_pkg::PH_IDLE;
          end else begin
            if (n == 4'd3) is_v4_next = (data_byte == id3tfe_pkg::SYNCSAFE_VERSION);
            if (n >= 4'd6) tag_size_next = tsize_new;
            hcount_next = n + 4'd1;
            if (n == 4'd9) begin
              tag_pos_next = '0;
              hcount_next  = '0;
              phase_next   = (tsize_new > 28'd10) ? id3tfe_pkg::PH_FRAME_HDR :
                                                     id3tfe_pkg::PH_IDLE;
            end
          end
        end
        id3tfe_pkg::PH_FRAME_HDR: begin
          if (n == 4'd0 && data_byte == id3tfe_pkg::PAD_BYTE) begin
            phase_next = id3tfe_pkg::PH_IDLE;
          end else begin
            if (n < 4'd4) frame_id_next = {frame_id[23:0], data_byte};
            if (n >= 4'd4 && n < 4'd8) size_raw_next = {size_raw[23:0], data_byte};
            hcount_next = n + 4'd1;
            if (n == 4'd9) begin
              hcount_next    = '0;
              tag_pos_next   = pos_plus;
              remaining_next = fsz;
              if (frame_ok && frame_id == id3tfe_pkg::ID_TIT2 &&
                  id3tfe_pkg::eff_size(title_size) != 9'd0) begin
                which_next = 1'b0;
                phase_next = id3tfe_pkg::PH_PAYLOAD;
              end else if (frame_ok && frame_id == id3tfe_pkg::ID_TPE1 &&
                           id3tfe_pkg::eff_size(artist_size) != 9'd0) begin
                which_next = 1'b1;
                phase_next = id3tfe_pkg::PH_PAYLOAD;
              end else if (fsz != 32'd0) begin
                phase_next = id3tfe_pkg::PH_SKIP;
              end else begin
                phase_next = ((tag_pos + 33'd20) < 33'(tag_size)) ?
                             id3tfe_pkg::PH_FRAME_HDR : id3tfe_pkg::PH_IDLE;
              end
              pidx_next     = '0;
              take2_next    = 1'b0;
              pending_next  = '0;
              encoding_next = '0;
            end
          end
        end
        id3tfe_pkg::PH_PAYLOAD: begin
          pidx_next      = pidx + IW'(1);
          remaining_next = remaining - 32'd1;
          rec.last       = (remaining == 32'd1);
          if (pidx == '0) begin
            encoding_next = data_byte;
            rec.start     = 1'b1;
          end else if (utf16) begin
            if (pidx == IW'(1)) begin
              pending_next = data_byte;
              take2_next   = (data_byte == id3tfe_pkg::BOM_BE) ||
                             (data_byte != id3tfe_pkg::BOM_LE &&
                              encoding == id3tfe_pkg::ENC_UTF16_BE);
            end else if (pidx == IW'(2) && (pending == id3tfe_pkg::BOM_LE ||
                                             pending == id3tfe_pkg::BOM_BE)) begin
              rec.cand = 1'b0;
            end else if (!pidx[0]) begin
              rec.code = cchar;
              rec.cand = (cchar >= id3tfe_pkg::CHAR_SPACE) &&
                         (cchar < id3tfe_pkg::CHAR_DEL);
            end else begin
              pending_next = data_byte;
            end
          end else begin
            rec.cand = (data_byte >= id3tfe_pkg::CHAR_SPACE);
          end
          push = rec.start || rec.cand || rec.last;
          if (rec.last) begin
            hcount_next = '0;
            phase_next  = more ? id3tfe_pkg::PH_FRAME_HDR : id3tfe_pkg::PH_IDLE;
          end
        end
        id3tfe_pkg::PH_SKIP: begin
          remaining_next = remaining - 32'd1;
          if (remaining == 32'd1) begin
            hcount_next = '0;
            phase_next  = more ? id3tfe_pkg::PH_FRAME_HDR : id3tfe_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_next = ph_cur;
        end
      endcase
    end
  end

endmodule

>>> src/id3tfe_queue.sv
// Short record queue between the front parser and the back emitter.
// Depends on id3tfe_pkg for the record type and depth.
module id3tfe_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  id3tfe_pkg::rec_t    push_rec,
  input  logic                pop,
  output id3tfe_pkg::rec_t    head,
  output id3tfe_pkg::qstat_t  stat
);

  id3tfe_pkg::rec_t mem [id3tfe_pkg::Q_DEPTH];
  logic [id3tfe_pkg::Q_AW-1:0] wptr, rptr;
  logic [id3tfe_pkg::Q_AW:0]   count;

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (id3tfe_pkg::Q_AW+1)'(push) - (id3tfe_pkg::Q_AW+1)'(pop);
    end
  end

  assign head       = mem[rptr];
  assign stat.full  = (count == (id3tfe_pkg::Q_AW+1)'(id3tfe_pkg::Q_DEPTH));
  assign stat.empty = (count == '0);

endmodule

>>> src/id3tfe_back.sv
// Back end: applies the buffer cap, tracks positions and trimmed length,
// and holds the result register. Depends on id3tfe_pkg.
module id3tfe_back (
  input  logic                clk,
  input  logic                rst,
  input  id3tfe_pkg::rec_t    head,
  input  id3tfe_pkg::qstat_t  stat,
  input  logic [8:0]          title_size,
  input  logic [8:0]          artist_size,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_stall,
  output logic                which_text,
  output logic                has_char,
  output logic [7:0]          char_code,
  output logic [7:0]          position,
  output logic                text_end,
  output logic [7:0]          text_length
);

  logic [7:0] written, written_next;
  logic [7:0] trimmed, trimmed_next;
  logic [8:0] size;
  logic [8:0] cap;
  logic [7:0] cw_base;
  logic [7:0] tl_base;
  logic       take;
  logic       emit;

  always_comb begin
    size    = id3tfe_pkg::eff_size(head.which ? artist_size : title_size);
    cap     = (size != 9'd0) ? size - 9'd1 : 9'd0;
    cw_base = head.start ? 8'd0 : written;
    tl_base = head.start ? 8'd0 : trimmed;
    take    = head.cand && ({1'b0, cw_base} < cap);
    written_next = take ? cw_base + 8'd1 : cw_base;
    trimmed_next = (take && head.code != id3tfe_pkg::CHAR_SPACE) ? written_next : tl_base;
    emit    = take || head.last;
    pop     = !stat.empty && (!result_valid || !result_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written      <= '0;
      trimmed      <= '0;
      result_valid <= 1'b0;
    end else if (pop) begin
      written      <= written_next;
      trimmed      <= trimmed_next;
      result_valid <= emit;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      which_text  <= head.which;
      has_char    <= take;
      char_code   <= take ? head.code : 8'd0;
      position    <= take ? cw_base : 8'd0;
      text_end    <= head.last;
      text_length <= head.last ? trimmed_next : 8'd0;
    end
  end

endmodule

>>> src/id3v2_text_frame_extractor.sv
// Top level of the ID3v2 text frame extractor: config registers, front parser,
// record queue and back emitter. Depends on id3tfe_pkg and the id3tfe_* modules.
//
//   channel  direction  handshake               payload
//   data     in         data_valid/data_stall   data_byte, start_of_file
//   result   out        result_valid/result_stall
//                       which_text, has_char, char_code, position,
//                       text_end, text_length
//   cfg      in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One byte per clock while data_stall is low; the front parser writes each result record
// into the queue, then the back end moves the queue head into the result register.
// A four-entry record queue lets the parser keep going while a result waits;
// data_stall rises only when that queue is full.
// rst is synchronous: the parser waits for a tag header, buffer sizes return to 256.
// cfg_ready is always high.
module id3v2_text_frame_extractor #(
  parameter int MAX_TEXT_FRAME = id3tfe_pkg::MAX_TEXT_FRAME
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       data_valid,
  output logic       data_stall,
  input  logic [7:0] data_byte,
  input  logic       start_of_file,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       which_text,
  output logic       has_char,
  output logic [7:0] char_code,
  output logic [7:0] position,
  output logic       text_end,
  output logic [7:0] text_length,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [0:0] cfg_index,
  input  logic [8:0] cfg_data
);

  logic [8:0] title_size;
  logic [8:0] artist_size;
  logic       accept;
  logic       push;
  logic       pop;
  id3tfe_pkg::rec_t   push_rec;
  id3tfe_pkg::rec_t   head;
  id3tfe_pkg::qstat_t stat;

  assign cfg_ready  = 1'b1;
  assign data_stall = stat.full;
  assign accept     = data_valid && !data_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      title_size  <= id3tfe_pkg::BUF_SIZE_RESET;
      artist_size <= id3tfe_pkg::BUF_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        id3tfe_pkg::REG_TITLE_SIZE:  title_size  <= cfg_data;
        id3tfe_pkg::REG_ARTIST_SIZE: artist_size <= cfg_data;
        default: title_size <= title_size;
      endcase
    end
  end

  id3tfe_front #(
    .MAX_TEXT_FRAME(MAX_TEXT_FRAME)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (data_byte),
    .start_of_file(start_of_file),
    .title_size   (title_size),
    .artist_size  (artist_size),
    .push         (push),
    .rec          (push_rec)
  );

  id3tfe_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_rec(push_rec),
    .pop     (pop),
    .head    (head),
    .stat    (stat)
  );

  id3tfe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .stat        (stat),
    .title_size  (title_size),
    .artist_size (artist_size),
    .pop         (pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .which_text  (which_text),
    .has_char    (has_char),
    .char_code   (char_code),
    .position    (position),
    .text_end    (text_end),
    .text_length (text_length)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && stat.full))
    else $error("record pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && stat.empty))
    else $error("record popped from an empty queue");

  a_result_has_content: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (has_char || text_end))
    else $error("result carries neither a character nor an end mark");

  a_char_printable: assert property (@(posedge clk) disable iff (rst)
    (result_valid && has_char) |-> (char_code >= id3tfe_pkg::CHAR_SPACE))
    else $error("emitted character below space");

endmodule

>>> test/tb_id3v2_text_frame_extractor.sv
// Self-checking testbench for id3v2_text_frame_extractor: builds tag files byte by byte,
// predicts every title and artist character and text end, and checks each result transfer.
// Depends on id3tfe_pkg and the extractor RTL in src.
module tb_id3v2_text_frame_extractor;
  timeunit 1ns;
  timeprecision 1ps;

  import id3tfe_pkg::*;

  localparam logic [7:0] ENC_LATIN = 8'h00;
  localparam logic [7:0] ENC_UTF8 = 8'h03;
  localparam logic [31:0] ID_TALB = 32'h5441_4C42;

  typedef enum logic [1:0] {
    FK_SKIP,
    FK_TITLE,
    FK_ARTIST
  } frame_kind_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  typedef struct packed {
    logic       which;
    logic       has;
    logic [7:0] code;
    logic [7:0] pos;
    logic       fin;
    logic [7:0] len;
  } text_out_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       data_valid = 1'b0;
  logic       data_stall;
  logic [7:0] data_byte = 8'h00;
  logic       start_of_file = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic       which_text;
  logic       has_char;
  logic [7:0] char_code;
  logic [7:0] position;
  logic       text_end;
  logic [7:0] text_length;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [0:0] cfg_index = REG_TITLE_SIZE;
  logic [8:0] cfg_data = 9'd0;

  id3v2_text_frame_extractor u_top (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_byte    (data_byte),
    .start_of_file(start_of_file),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .which_text   (which_text),
    .has_char     (has_char),
    .char_code    (char_code),
    .position     (position),
    .text_end     (text_end),
    .text_length  (text_length),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("id3v2_text_frame_extractor test failed");
    $finish;
  end

  // Parser shadow
  logic [8:0]  title_size = BUF_SIZE_RESET;
  logic [8:0]  artist_size = BUF_SIZE_RESET;
  phase_t      ph;
  logic [3:0]  hdr_cnt;
  logic [7:0]  version;
  logic [27:0] tag_len;
  logic [63:0] tag_pos;
  logic [7:0]  fhdr [10];
  logic [31:0] frame_left;
  frame_kind_t kind;
  logic [7:0]  enc;
  logic [8:0]  pay_idx;
  logic        second;
  logic [7:0]  held;
  logic [8:0]  n_chars;
  logic [7:0]  trim_len;

  text_out_t   expected_text_q [$];
  logic [7:0]  file_q [$];

  int n_bytes = 0;
  int n_files = 0;
  int n_results = 0;
  int n_mismatch = 0;
  int n_settings = 0;
  int burst_left = 0;
  int gap_max = 4;

  function automatic logic [8:0] buf_limit(input logic [8:0] r);
    int v;
    v = r;
    if (v > TEXT_BUFFER_MAX) v = TEXT_BUFFER_MAX;
    if (v > 256) v = 256;
    return 9'(v);
  endfunction

  task automatic clear_parse();
    ph = PH_TAG_HDR;
    hdr_cnt = '0;
    version = '0;
    tag_len = '0;
    tag_pos = '0;
    for (int i = 0; i < 10; i++) fhdr[i] = '0;
    frame_left = '0;
    kind = FK_SKIP;
    enc = '0;
    pay_idx = '0;
    second = 1'b0;
    held = '0;
    n_chars = '0;
    trim_len = '0;
  endtask

  task automatic close_frame();
    hdr_cnt = '0;
    ph = (tag_pos + 64'd10 < {36'd0, tag_len}) ? PH_FRAME_HDR : PH_IDLE;
  endtask

  task automatic decode_frame_header();
    logic [31:0] fsz;
    logic [31:0] id;
    id = {fhdr[0], fhdr[1], fhdr[2], fhdr[3]};
    if (version == SYNCSAFE_VERSION)
      fsz = {4'd0, fhdr[4][6:0], fhdr[5][6:0], fhdr[6][6:0], fhdr[7][6:0]};
    else
      fsz = {fhdr[4], fhdr[5], fhdr[6], fhdr[7]};
    kind = FK_SKIP;
    if ((fhdr[9] & FLAG_MASK) == 8'h00 && fsz != 0 && fsz < 32'(MAX_TEXT_FRAME)) begin
      if (id == ID_TIT2 && buf_limit(title_size) != 0) kind = FK_TITLE;
      else if (id == ID_TPE1 && buf_limit(artist_size) != 0) kind = FK_ARTIST;
    end
    tag_pos = tag_pos + 64'd10 + {32'd0, fsz};
    frame_left = fsz;
    if (kind != FK_SKIP) begin
      ph = PH_PAYLOAD;
      pay_idx = '0;
      n_chars = '0;
      trim_len = '0;
      second = 1'b0;
      held = '0;
      enc = '0;
    end else if (fsz != 0) begin
      ph = PH_SKIP;
    end else begin
      close_frame();
    end
  endtask

  function automatic bit keep_char(input logic [7:0] c, output logic [7:0] p);
    logic [8:0] sz;
    logic [8:0] cap;
    sz = buf_limit(kind == FK_ARTIST ? artist_size : title_size);
    cap = (sz != 0) ? sz - 9'd1 : 9'd0;
    p = 8'd0;
    if (n_chars >= cap) return 1'b0;
    p = n_chars[7:0];
    n_chars = n_chars + 9'd1;
    if (c != CHAR_SPACE) trim_len = n_chars[7:0];
    return 1'b1;
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic sof);
    text_out_t  r;
    logic [3:0] n;
    logic [8:0] j;
    logic [7:0] c;
    logic [7:0] p;
    r = '0;
    if (sof) clear_parse();
    case (ph)
      PH_TAG_HDR: begin
        n = hdr_cnt;
        if ((n == 0 && b != MAGIC_0) || (n == 1 && b != MAGIC_1) || (n == 2 && b != MAGIC_2)) begin
          ph = PH_IDLE;
        end else if (n == 3 && b < MIN_VERSION) begin
          version = b;
          ph = PH_IDLE;
        end else begin
          if (n == 3) version = b;
          if (n >= 6) tag_len = {tag_len[20:0], b[6:0]};
          hdr_cnt = n + 4'd1;
          if (n == 9) begin
            tag_pos = '0;
            close_frame();
          end
        end
      end
      PH_FRAME_HDR: begin
        n = hdr_cnt;
        if (n == 0 && b == PAD_BYTE) begin
          ph = PH_IDLE;
        end else begin
          if (n < 10) fhdr[n] = b;
          hdr_cnt = n + 4'd1;
          if (n >= 9) decode_frame_header();
        end
      end
      PH_PAYLOAD: begin
        r.which = (kind == FK_ARTIST);
        if (pay_idx == 0) begin
          enc = b;
        end else begin
          j = pay_idx - 9'd1;
          if (enc == ENC_UTF16_BOM || enc == ENC_UTF16_BE) begin
            if (j == 0) begin
              held = b;
              second = (b == BOM_BE) || (b != BOM_LE && enc == ENC_UTF16_BE);
            end else if (!(j == 1 && (held == BOM_LE || held == BOM_BE))) begin
              if (!j[0]) begin
                held = b;
              end else begin
                c = second ? b : held;
                if (c >= CHAR_SPACE && c < CHAR_DEL) begin
                  if (keep_char(c, p)) begin
                    r.has = 1'b1;
                    r.code = c;
                    r.pos = p;
                  end
                end
              end
            end
          end else if (b >= CHAR_SPACE) begin
            if (keep_char(b, p)) begin
              r.has = 1'b1;
              r.code = b;
              r.pos = p;
            end
          end
        end
        pay_idx = pay_idx + 9'd1;
        frame_left = frame_left - 32'd1;
        if (frame_left == 0) begin
          r.fin = 1'b1;
          r.len = trim_len;
          close_frame();
        end
      end
      PH_SKIP: begin
        if (frame_left > 0) frame_left = frame_left - 32'd1;
        if (frame_left == 0) close_frame();
      end
      default: ;
    endcase
    if (r.has || r.fin) expected_text_q.push_back(r);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic sof);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        data_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    data_valid <= 1'b1;
    data_byte <= b;
    start_of_file <= sof;
    do @(posedge clk); while (data_stall);
    predict_byte(b, sof);
    burst_left--;
    n_bytes++;
  endtask

  task automatic send_file(input bit sof_first);
    for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], sof_first && i == 0);
    file_q.delete();
    n_files++;
  endtask

  task automatic settle();
    data_valid <= 1'b0;
    while (expected_text_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_sizes(input logic [8:0] t, input logic [8:0] a);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= REG_TITLE_SIZE;
    cfg_data <= t;
    do @(posedge clk); while (!cfg_ready);
    title_size = t;
    cfg_index <= REG_ARTIST_SIZE;
    cfg_data <= a;
    do @(posedge clk); while (!cfg_ready);
    artist_size = a;
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic patch_syncsafe(input int at, input logic [27:0] v);
    bit   noisy;
    logic top;
    noisy = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < 4; i++) begin
      top = noisy && ($urandom_range(0, 1) == 1);
      file_q[at + i] = {top, v[27 - 7 * i -: 7]};
    end
  endtask

  task automatic put_tag_header(input logic [7:0] ver, input logic [27:0] size);
    file_q = {file_q, MAGIC_0, MAGIC_1, MAGIC_2, ver, 8'($urandom), 8'($urandom),
              8'h00, 8'h00, 8'h00, 8'h00};
    patch_syncsafe(file_q.size() - 4, size);
  endtask

  task automatic put_frame_header(input logic [31:0] id, input logic [31:0] fsz,
                                  input logic [7:0] ver, input logic [7:0] flags);
    int at;
    file_q = {file_q, id[31:24], id[23:16], id[15:8], id[7:0],
              8'h00, 8'h00, 8'h00, 8'h00, 8'($urandom), flags};
    at = file_q.size() - 6;
    if (ver == SYNCSAFE_VERSION) patch_syncsafe(at, fsz[27:0]);
    else for (int i = 0; i < 4; i++) file_q[at + i] = fsz[31 - 8 * i -: 8];
  endtask

  function automatic logic [7:0] text_char();
    int k;
    k = $urandom_range(0, 99);
    if (k < 78) return 8'($urandom_range(8'h21, 8'h7E));
    if (k < 90) return CHAR_SPACE;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_encoding();
    int k;
    k = $urandom_range(0, 99);
    if (k < 35) return ENC_LATIN;
    if (k < 60) return ENC_UTF16_BOM;
    if (k < 80) return ENC_UTF16_BE;
    if (k < 88) return ENC_UTF8;
    return 8'($urandom);
  endfunction

  function automatic logic [8:0] pick_size();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) return 9'($urandom_range(0, 40));
    if (k < 7) begin
      case ($urandom_range(0, 5))
        0: return 9'd0;
        1: return 9'd1;
        2: return 9'd2;
        3: return 9'd255;
        4: return 9'd256;
        default: return 9'd511;
      endcase
    end
    return 9'($urandom_range(0, 511));
  endfunction

  task automatic put_text_payload(input logic [31:0] fsz, input logic [7:0] e);
    int         rest;
    int         tail;
    int         bom;
    bit         utf16;
    bit         big;
    logic [7:0] c;
    logic [7:0] other;
    file_q.push_back(e);
    rest = fsz - 1;
    utf16 = (e == ENC_UTF16_BOM || e == ENC_UTF16_BE);
    bom = utf16 ? $urandom_range(0, 2) : 0;
    big = (bom == 2) || (bom == 0 && e == ENC_UTF16_BE);
    if (bom != 0 && rest >= 2) begin
      file_q.push_back(bom == 1 ? BOM_LE : BOM_BE);
      file_q.push_back(bom == 1 ? BOM_BE : BOM_LE);
      rest -= 2;
    end
    tail = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
    while (rest > 0) begin
      c = (rest <= (utf16 ? 2 * tail : tail)) ? CHAR_SPACE : text_char();
      if (!utf16) begin
        file_q.push_back(c);
        rest--;
      end else begin
        other = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00;
        file_q.push_back(big ? other : c);
        rest--;
        if (rest > 0) begin
          file_q.push_back(big ? c : other);
          rest--;
        end
      end
    end
  endtask

  task automatic random_file();
    int          r;
    int          k;
    int          body;
    int          pad;
    bit          cut;
    logic [7:0]  ver;
    logic [31:0] id;
    logic [31:0] fsz;
    logic [7:0]  flags;
    logic [27:0] tsz;
    r = $urandom_range(0, 99);
    file_q.delete();
    if (r < 5) begin
      repeat ($urandom_range(1, 15)) file_q.push_back(8'($urandom));
    end else if (r < 9) begin
      put_tag_header(8'($urandom_range(0, 2)), 28'($urandom));
      repeat ($urandom_range(0, 6)) file_q.push_back(8'($urandom));
    end else begin
      ver = (r < 13) ? 8'($urandom_range(5, 255)) : (r[0] ? MIN_VERSION : SYNCSAFE_VERSION);
      put_tag_header(ver, 28'd0);
      body = 0;
      pad = 0;
      cut = 1'b0;
      repeat ($urandom_range(1, 4)) begin
        if (!cut) begin
          k = $urandom_range(0, 99);
          id = (k < 40) ? ID_TIT2 : (k < 75) ? ID_TPE1 : (k < 85) ? ID_TALB : $urandom;
          k = $urandom_range(0, 99);
          if (k < 3) fsz = 0;
          else if (k < 8)
            fsz = (ver == SYNCSAFE_VERSION) ? $urandom_range(512, 28'hFFF_FFFF)
                                            : $urandom_range(512, 32'hFFFF_FFFF);
          else if (k < 14) fsz = $urandom_range(100, 511);
          else fsz = $urandom_range(1, 40);
          flags = 8'($urandom);
          if ($urandom_range(0, 99) < 85) flags = flags & ~FLAG_MASK;
          put_frame_header(id, fsz, ver, flags);
          if (fsz >= 32'(MAX_TEXT_FRAME)) begin
            repeat ($urandom_range(0, 20)) file_q.push_back(8'($urandom));
            cut = 1'b1;
          end else begin
            if (fsz != 0) put_text_payload(fsz, pick_encoding());
            body += 10 + fsz;
            if (fsz != 0 && $urandom_range(0, 19) == 0) begin
              repeat ($urandom_range(1, fsz)) void'(file_q.pop_back());
              cut = 1'b1;
            end
          end
        end
      end
      if (!cut) begin
        pad = $urandom_range(0, 8);
        repeat (pad) file_q.push_back(PAD_BYTE);
        repeat ($urandom_range(0, 4)) file_q.push_back(8'($urandom));
      end
      tsz = 28'(body + pad);
      if ($urandom_range(0, 99) < 15) tsz = 28'($urandom_range(0, body + pad + 20));
      patch_syncsafe(6, tsz);
    end
    send_file(1'b1);
  endtask

  // Receiver stall pattern
  rx_mode_t   rx_mode = RX_OPEN;
  int         rx_left = 0;
  logic [7:0] rx_tick = 8'd0;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 8'd1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN: result_stall <= 1'b0;
      RX_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
      default: result_stall <= rx_tick[3] & ~rx_tick[1];
    endcase
  end

  function automatic void report_mismatch(input string what, input text_out_t want,
                                          input text_out_t got);
    n_mismatch++;
    if (n_mismatch <= 10)
      $display("%0t %s: expected which=%0d has=%0d code=%02h pos=%0d end=%0d len=%0d, got which=%0d has=%0d code=%02h pos=%0d end=%0d len=%0d",
               $realtime, what, want.which, want.has, want.code, want.pos, want.fin, want.len,
               got.which, got.has, got.code, got.pos, got.fin, got.len);
  endfunction

  always @(posedge clk) begin
    text_out_t got;
    text_out_t want;
    if (!rst && result_valid && !result_stall) begin
      got = {which_text, has_char, char_code, position, text_end, text_length};
      n_results++;
      if (expected_text_q.size() == 0) begin
        report_mismatch("unexpected transfer", '0, got);
      end else begin
        want = expected_text_q.pop_front();
        if (got !== want) report_mismatch("wrong transfer", want, got);
      end
    end
  end

  task automatic test_frame_walk();
    // no start mark after reset: first file goes in with start_of_file low
    put_tag_header(MIN_VERSION, 28'd50);
    put_frame_header(ID_TIT2, 32'd6, MIN_VERSION, 8'h00);
    file_q = {file_q, ENC_LATIN, "A", 8'h1F, "b", " ", " "};
    put_frame_header(ID_TPE1, 32'd8, MIN_VERSION, 8'h00);
    file_q = {file_q, ENC_UTF16_BOM, BOM_LE, BOM_BE, "X", 8'h00, "Y", 8'h00, "Z"};
    put_frame_header(ID_TIT2, 32'd3, MIN_VERSION, 8'h08);
    file_q = {file_q, ENC_LATIN, "a", "b"};
    file_q = {file_q, PAD_BYTE, PAD_BYTE, PAD_BYTE};
    send_file(1'b0);

    put_tag_header(SYNCSAFE_VERSION, 28'd75);
    put_frame_header(ID_TIT2, 32'd5, SYNCSAFE_VERSION, 8'h00);
    file_q = {file_q, ENC_UTF16_BE, 8'h00, "Q", 8'h00, "r"};
    put_frame_header(ID_TPE1, 32'd5, SYNCSAFE_VERSION, 8'h00);
    file_q = {file_q, ENC_UTF16_BOM, BOM_BE, BOM_LE, 8'h00, "z"};
    put_frame_header(ID_TIT2, 32'd1, SYNCSAFE_VERSION, 8'h00);
    file_q = {file_q, ENC_UTF8};
    put_frame_header(ID_TPE1, 32'd0, SYNCSAFE_VERSION, 8'h00);
    put_frame_header(ID_TIT2, 32'd2, SYNCSAFE_VERSION, 8'h04);
    file_q = {file_q, ENC_LATIN, "k"};
    put_frame_header(ID_TALB, 32'd2, SYNCSAFE_VERSION, 8'h00);
    file_q = {file_q, ENC_LATIN, "m"};
    file_q = {file_q, 8'hFF, 8'hFB, 8'h90};
    send_file(1'b1);
  endtask

  task automatic test_bad_headers();
    file_q = {file_q, MAGIC_0, MAGIC_1, 8'h58, MIN_VERSION, 8'h00, 8'h00, 8'h00, 8'h7F};
    send_file(1'b1);
    put_tag_header(8'd2, 28'd30);
    put_frame_header(ID_TIT2, 32'd4, 8'd2, 8'h00);
    file_q = {file_q, ENC_LATIN, "n", "o", "!"};
    send_file(1'b1);
  endtask

  task automatic test_oversize_and_truncation();
    put_tag_header(MIN_VERSION, 28'd2000);
    put_frame_header(ID_TIT2, 32'(MAX_TEXT_FRAME), MIN_VERSION, 8'h00);
    repeat (30) file_q.push_back(text_char());
    send_file(1'b1);
    put_tag_header(SYNCSAFE_VERSION, 28'd600);
    put_frame_header(ID_TPE1, 32'd511, SYNCSAFE_VERSION, 8'h00);
    file_q.push_back(ENC_LATIN);
    repeat (40) file_q.push_back(text_char());
    send_file(1'b1);
  endtask

  task automatic test_buffer_sizes();
    logic [8:0] t_set [7];
    logic [8:0] a_set [7];
    t_set = '{9'd0, 9'd256, 9'd1, 9'd2, 9'd511, 9'd0, 9'd255};
    a_set = '{9'd256, 9'd0, 9'd1, 9'd3, 9'd255, 9'd0, 9'd511};
    for (int i = 0; i < 7; i++) begin
      set_sizes(t_set[i], a_set[i]);
      if (i == 4) begin
        put_tag_header(MIN_VERSION, 28'd590);
        put_frame_header(ID_TIT2, 32'd300, MIN_VERSION, 8'h00);
        put_text_payload(32'd300, ENC_LATIN);
        put_frame_header(ID_TPE1, 32'd270, MIN_VERSION, 8'h00);
        put_text_payload(32'd270, ENC_UTF8);
        send_file(1'b1);
      end
      repeat (2) random_file();
    end
  endtask

  task automatic test_random_files();
    int files;
    int first;
    files = 0;
    first = n_bytes;
    set_sizes(BUF_SIZE_RESET, BUF_SIZE_RESET);
    while (n_bytes - first < 1250) begin
      case ($urandom_range(0, 2))
        0: gap_max = 0;
        1: gap_max = 2;
        default: gap_max = 6;
      endcase
      random_file();
      files++;
      if (files % 7 == 0) set_sizes(pick_size(), pick_size());
      else if (files % 5 == 2) settle();
    end
  endtask

  initial begin
    clear_parse();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_frame_walk();
    test_bad_headers();
    test_oversize_and_truncation();
    test_buffer_sizes();
    test_random_files();
    settle();
    $display("Sent %0d bytes in %0d files under %0d buffer size settings.",
             n_bytes, n_files, n_settings);
    $display("Checked %0d result transfers, %0d mismatches.", n_results, n_mismatch);
    if (n_mismatch == 0 && expected_text_q.size() == 0) begin
      $display("id3v2_text_frame_extractor test passed");
    end else begin
      $display("id3v2_text_frame_extractor test failed");
    end
    $finish;
  end

endmodule
